### src/lzd_pkg.sv
`default_nettype none
package lzd_pkg;

  // Sizes of the input byte queue and of the history window.
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  localparam int AVAIL_W      = FIFO_CW + 3;
  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

  // Request codes.
  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_PULL    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_FULL   = 3'd1,
    ST_BYTE   = 3'd2,
    ST_STARVE = 3'd3,
    ST_ERROR  = 3'd4
  } status_e;

  // Bit stream parse phases.
  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_HAS   = 3'd1,
    PH_LOW   = 3'd2,
    PH_MSB_Z = 3'd3,
    PH_MSB_B = 3'd4,
    PH_LEN_Z = 3'd5,
    PH_LEN_B = 3'd6,
    PH_RUN   = 3'd7
  } phase_e;

  // Current command kind.
  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_LIT  = 2'd1,
    K_LAST = 2'd2,
    K_NEW  = 2'd3
  } kind_e;

  // Execution engine states.
  typedef enum logic [2:0] {
    E_IDLE,
    E_PULL,
    E_SHIFT,
    E_RD,
    E_RDW
  } eng_state_e;

  // One queued request.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data;
  } req_t;

endpackage
`default_nettype wire

### src/lzd_front.sv
`default_nettype none
module lzd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_req_type,
  input  wire logic [7:0]   in_byte,
  output logic              req_valid,
  input  wire logic         req_ready,
  output lzd_pkg::req_t     req
);

  // Two-entry request queue between the port and the engine.
  lzd_pkg::req_t q_r [2];
  logic          rd_ptr_r, rd_ptr_nxt;
  logic          wr_ptr_r, wr_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = req_valid && req_ready;

  // Pointer and occupancy update.
  always_comb begin
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].req_type <= in_req_type;
      q_r[wr_ptr_r].data     <= in_byte;
    end
  end

  qfull_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |=> (cnt_r != 2'd0))
    else $error("queue drained by more than one entry in a cycle");
  qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd3))
    else $error("queue occupancy out of range");
  qpop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |=> (cnt_r != 2'd2))
    else $error("queue grew by two in one cycle");

endmodule
`default_nettype wire

### src/lzd_back.sv
`default_nettype none
module lzd_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         req_valid,
  output logic              req_ready,
  input  wire lzd_pkg::req_t req,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_status,
  output logic [7:0]        out_byte,
  output logic [31:0]       out_total_size,
  output logic              out_size_known
);

  localparam int FD = lzd_pkg::FIFO_DEPTH;
  localparam int FA = lzd_pkg::FIFO_AW;
  localparam int FC = lzd_pkg::FIFO_CW;
  localparam int AW = lzd_pkg::AVAIL_W;
  localparam int WA = lzd_pkg::WIN_AW;

  lzd_pkg::eng_state_e st_r, st_nxt;

  // Compressed byte queue and bit reader.
  logic [7:0]    fifo_mem_r [FD];
  logic [FA-1:0] head_r, head_nxt;
  logic [FC-1:0] cnt_r, cnt_nxt;
  logic [2:0]    bitpos_r, bitpos_nxt;

  // Header and decoder state.
  logic [2:0]    hc_r, hc_nxt;
  logic [31:0]   size_r, size_nxt;
  logic [WA-1:0] wpos_r, wpos_nxt;
  logic [31:0]   prod_r, prod_nxt;
  lzd_pkg::kind_e  kind_r, kind_nxt;
  lzd_pkg::phase_e phase_r, phase_nxt;
  logic [31:0]   run_r, run_nxt;
  logic [31:0]   lastoff_r, lastoff_nxt;
  logic [5:0]    gz_r, gz_nxt;
  logic [31:0]   ga_r, ga_nxt;
  logic          err_r, err_nxt;
  logic          has_r, has_nxt;
  logic [6:0]    low_r, low_nxt;
  logic [3:0]    shcnt_r, shcnt_nxt;
  logic [7:0]    sh_r, sh_nxt;

  // Result register.
  logic          ov_r, ov_nxt;
  logic [2:0]    ostat_r, ostat_nxt;
  logic [7:0]    obyte_r, obyte_nxt;

  // History window.
  logic [7:0]    win_mem [lzd_pkg::WINDOW_DEPTH];
  logic [7:0]    rd_data_r;
  logic [WA-1:0] src_addr;
  logic          wr_en;
  logic [7:0]    wr_data;

  // Step flags shared by the state machine and the datapath.
  logic          req_take, done, go_shift, go_rd;
  logic [AW-1:0] avail;
  logic          cur_bit;
  logic          fifo_push;

  // Working values.
  logic          len_fire, off_fire, take1;
  logic [31:0]   len_val, off_msb, ga_shift, run_v;
  logic [6:0]    low_v;
  logic [32:0]   off_sum;
  logic [5:0]    gz_inc;

  assign req_ready  = (st_r == lzd_pkg::E_IDLE) && !ov_r;
  assign req_take   = req_valid && req_ready;
  assign avail      = {cnt_r, 3'b000} - {{(AW-3){1'b0}}, bitpos_r};
  assign cur_bit    = fifo_mem_r[head_r][3'd7 - bitpos_r];
  assign src_addr   = wpos_r - lastoff_r[WA-1:0];

  assign out_valid      = ov_r;
  assign out_status     = ostat_r;
  assign out_byte       = obyte_r;
  assign out_size_known = (hc_r == 3'd4);
  assign out_total_size = (hc_r == 3'd4) ? size_r : 32'd0;

  // Next state of the engine.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lzd_pkg::E_IDLE: begin
        if (req_take && req.req_type == lzd_pkg::REQ_PULL) st_nxt = lzd_pkg::E_PULL;
      end
      lzd_pkg::E_PULL: begin
        if (done)          st_nxt = lzd_pkg::E_IDLE;
        else if (go_shift) st_nxt = lzd_pkg::E_SHIFT;
        else if (go_rd)    st_nxt = lzd_pkg::E_RD;
      end
      lzd_pkg::E_SHIFT: begin
        if (done)                 st_nxt = lzd_pkg::E_IDLE;
        else if (shcnt_r == 4'd1) st_nxt = lzd_pkg::E_PULL;
      end
      lzd_pkg::E_RD:  st_nxt = lzd_pkg::E_RDW;
      lzd_pkg::E_RDW: st_nxt = lzd_pkg::E_IDLE;
      default:        st_nxt = lzd_pkg::E_IDLE;
    endcase
  end

  // Datapath: one parse step per cycle, request handling and emission.
  always_comb begin
    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    bitpos_nxt  = bitpos_r;
    hc_nxt      = hc_r;
    size_nxt    = size_r;
    wpos_nxt    = wpos_r;
    prod_nxt    = prod_r;
    kind_nxt    = kind_r;
    phase_nxt   = phase_r;
    run_nxt     = run_r;
    lastoff_nxt = lastoff_r;
    gz_nxt      = gz_r;
    ga_nxt      = ga_r;
    err_nxt     = err_r;
    has_nxt     = has_r;
    low_nxt     = low_r;
    shcnt_nxt   = shcnt_r;
    sh_nxt      = sh_r;
    ov_nxt      = ov_r && !out_ready;
    ostat_nxt   = ostat_r;
    obyte_nxt   = obyte_r;
    done        = 1'b0;
    go_shift    = 1'b0;
    go_rd       = 1'b0;
    fifo_push   = 1'b0;
    wr_en       = 1'b0;
    wr_data     = sh_r;
    len_fire    = 1'b0;
    off_fire    = 1'b0;
    take1       = 1'b0;
    len_val     = 32'd0;
    off_msb     = 32'd0;
    low_v       = low_r;
    ga_shift    = {ga_r[30:0], cur_bit};
    gz_inc      = gz_r + 6'd1;
    run_v       = 32'd0;
    off_sum     = 33'd0;

    case (st_r)
      lzd_pkg::E_IDLE: begin
        if (req_take) begin
          case (req.req_type)
            lzd_pkg::REQ_PUSH: begin
              ov_nxt = 1'b1;
              obyte_nxt = 8'd0;
              if (hc_r != 3'd4) begin
                size_nxt  = size_r | ({24'd0, req.data} << {hc_r[1:0], 3'b000});
                hc_nxt    = hc_r + 3'd1;
                ostat_nxt = lzd_pkg::ST_PUSHED;
              end else if (cnt_r == FC'(FD)) begin
                ostat_nxt = lzd_pkg::ST_FULL;
              end else begin
                fifo_push = 1'b1;
                cnt_nxt   = cnt_r + FC'(1);
                ostat_nxt = lzd_pkg::ST_PUSHED;
              end
            end
            lzd_pkg::REQ_RESTART: begin
              head_nxt    = '0;
              cnt_nxt     = '0;
              bitpos_nxt  = 3'd0;
              hc_nxt      = 3'd0;
              size_nxt    = 32'd0;
              wpos_nxt    = '0;
              prod_nxt    = 32'd0;
              kind_nxt    = lzd_pkg::K_NONE;
              phase_nxt   = lzd_pkg::PH_CMD;
              run_nxt     = 32'd0;
              lastoff_nxt = '1;
              gz_nxt      = 6'd0;
              ga_nxt      = 32'd0;
              err_nxt     = 1'b0;
              has_nxt     = 1'b0;
              low_nxt     = 7'd0;
              ov_nxt      = 1'b1;
              ostat_nxt   = lzd_pkg::ST_PUSHED;
              obyte_nxt   = 8'd0;
            end
            lzd_pkg::REQ_PULL: begin
            end
            default: begin
              ov_nxt    = 1'b1;
              ostat_nxt = lzd_pkg::ST_STARVE;
              obyte_nxt = 8'd0;
            end
          endcase
        end
      end

      lzd_pkg::E_PULL: begin
        if (err_r) begin
          done = 1'b1;
          ostat_nxt = lzd_pkg::ST_ERROR;
        end else if (hc_r != 3'd4) begin
          done = 1'b1;
          ostat_nxt = lzd_pkg::ST_STARVE;
        end else if (phase_r == lzd_pkg::PH_RUN) begin
          if (run_r == 32'd0) begin
            phase_nxt = lzd_pkg::PH_CMD;
          end else if (kind_r == lzd_pkg::K_LIT) begin
            if (avail < AW'(8)) begin
              done = 1'b1;
              ostat_nxt = lzd_pkg::ST_STARVE;
            end else begin
              go_shift  = 1'b1;
              shcnt_nxt = 4'd8;
            end
          end else begin
            go_rd = 1'b1;
          end
        end else if (phase_r == lzd_pkg::PH_LOW) begin
          if (avail < AW'(7)) begin
            done = 1'b1;
            ostat_nxt = lzd_pkg::ST_STARVE;
          end else begin
            go_shift  = 1'b1;
            shcnt_nxt = 4'd7;
          end
        end else if (avail == AW'(0)) begin
          done = 1'b1;
          ostat_nxt = lzd_pkg::ST_STARVE;
        end else begin
          take1 = 1'b1;
          case (phase_r)
            lzd_pkg::PH_CMD: begin
              if (cur_bit) begin
                kind_nxt  = lzd_pkg::K_NEW;
                phase_nxt = lzd_pkg::PH_HAS;
              end else begin
                kind_nxt  = (kind_r == lzd_pkg::K_LIT) ? lzd_pkg::K_LAST : lzd_pkg::K_LIT;
                gz_nxt    = 6'd0;
                phase_nxt = lzd_pkg::PH_LEN_Z;
              end
            end
            lzd_pkg::PH_HAS: begin
              has_nxt   = cur_bit;
              phase_nxt = lzd_pkg::PH_LOW;
            end
            lzd_pkg::PH_MSB_Z, lzd_pkg::PH_LEN_Z: begin
              if (!cur_bit) begin
                gz_nxt = gz_inc;
                if (gz_inc[5]) err_nxt = 1'b1;
              end else begin
                ga_nxt = 32'd1;
                if (gz_r != 6'd0) begin
                  phase_nxt = (phase_r == lzd_pkg::PH_MSB_Z) ? lzd_pkg::PH_MSB_B
                                                             : lzd_pkg::PH_LEN_B;
                end else if (phase_r == lzd_pkg::PH_MSB_Z) begin
                  off_fire = 1'b1;
                end else begin
                  len_fire = 1'b1;
                end
              end
            end
            default: begin
              // Value bits of a gamma code.
              ga_nxt = ga_shift;
              gz_nxt = gz_r - 6'd1;
              if (gz_r == 6'd1) begin
                if (phase_r == lzd_pkg::PH_MSB_B) begin
                  off_fire = 1'b1;
                  off_msb  = ga_shift - 32'd1;
                end else begin
                  len_fire = 1'b1;
                  len_val  = ga_shift - 32'd1;
                end
              end
            end
          endcase
        end
        if (done) obyte_nxt = 8'd0;
      end

      lzd_pkg::E_SHIFT: begin
        // Gather literal or offset bits, one per cycle.
        take1     = 1'b1;
        sh_nxt    = {sh_r[6:0], cur_bit};
        shcnt_nxt = shcnt_r - 4'd1;
        if (shcnt_r == 4'd1) begin
          if (phase_r == lzd_pkg::PH_RUN) begin
            done      = 1'b1;
            wr_en     = 1'b1;
            wr_data   = {sh_r[6:0], cur_bit};
            ostat_nxt = lzd_pkg::ST_BYTE;
            obyte_nxt = {sh_r[6:0], cur_bit};
          end else begin
            low_v   = {sh_r[5:0], cur_bit};
            low_nxt = low_v;
            if (has_r) begin
              gz_nxt    = 6'd0;
              phase_nxt = lzd_pkg::PH_MSB_Z;
            end else begin
              off_fire = 1'b1;
            end
          end
        end
      end

      lzd_pkg::E_RD: begin
      end

      lzd_pkg::E_RDW: begin
        done      = 1'b1;
        wr_en     = 1'b1;
        wr_data   = rd_data_r;
        ostat_nxt = lzd_pkg::ST_BYTE;
        obyte_nxt = rd_data_r;
      end

      default: begin
      end
    endcase

    if (done) ov_nxt = 1'b1;

    // Consume one bit from the byte queue.
    if (take1) begin
      bitpos_nxt = bitpos_r + 3'd1;
      if (bitpos_r == 3'd7) begin
        head_nxt = head_r + FA'(1);
        cnt_nxt  = cnt_r - FC'(1);
      end
    end

    // Offset complete: msb and low fields plus one, saturating to all ones on overflow.
    if (off_fire) begin
      off_sum = {1'b0, off_msb[24:0], low_v} + 33'd1;
      lastoff_nxt = (off_msb[31:25] != 7'd0 || off_sum[32]) ? '1 : off_sum[31:0];
      gz_nxt      = 6'd0;
      phase_nxt   = lzd_pkg::PH_LEN_Z;
    end

    // Length complete: arm the run and check the copy distance.
    if (len_fire) begin
      run_v   = (kind_r == lzd_pkg::K_NEW) ? len_val + 32'd1 : len_val;
      run_nxt = run_v;
      if (kind_r != lzd_pkg::K_LIT && run_v != 32'd0 &&
          (lastoff_r > 32'(lzd_pkg::WINDOW_DEPTH) || lastoff_r > prod_r)) begin
        err_nxt = 1'b1;
      end
      phase_nxt = lzd_pkg::PH_RUN;
    end

    // Emit one byte into the window.
    if (wr_en) begin
      wpos_nxt = wpos_r + WA'(1);
      if (prod_r != 32'hFFFF_FFFF) prod_nxt = prod_r + 32'd1;
      run_nxt = run_r - 32'd1;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= lzd_pkg::E_IDLE;
      head_r    <= '0;
      cnt_r     <= '0;
      bitpos_r  <= 3'd0;
      hc_r      <= 3'd0;
      size_r    <= 32'd0;
      wpos_r    <= '0;
      prod_r    <= 32'd0;
      kind_r    <= lzd_pkg::K_NONE;
      phase_r   <= lzd_pkg::PH_CMD;
      run_r     <= 32'd0;
      lastoff_r <= '1;
      gz_r      <= 6'd0;
      ga_r      <= 32'd0;
      err_r     <= 1'b0;
      has_r     <= 1'b0;
      low_r     <= 7'd0;
      shcnt_r   <= 4'd0;
      ov_r      <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      bitpos_r  <= bitpos_nxt;
      hc_r      <= hc_nxt;
      size_r    <= size_nxt;
      wpos_r    <= wpos_nxt;
      prod_r    <= prod_nxt;
      kind_r    <= kind_nxt;
      phase_r   <= phase_nxt;
      run_r     <= run_nxt;
      lastoff_r <= lastoff_nxt;
      gz_r      <= gz_nxt;
      ga_r      <= ga_nxt;
      err_r     <= err_nxt;
      has_r     <= has_nxt;
      low_r     <= low_nxt;
      shcnt_r   <= shcnt_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    ostat_r <= ostat_nxt;
    obyte_r <= obyte_nxt;
    if (fifo_push) fifo_mem_r[FA'(head_r + cnt_r[FA-1:0])] <= req.data;
  end

  // History window memory.
  always_ff @(posedge clk) begin
    if (wr_en) win_mem[wpos_r] <= wr_data;
    rd_data_r <= win_mem[src_addr];
  end

  fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FC'(FD))
    else $error("byte queue overfilled");
  partial_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    (bitpos_r != 3'd0) |-> (cnt_r != '0))
    else $error("bit position inside an absent byte");
  byte_zero_unless_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ostat_r != lzd_pkg::ST_BYTE) |-> (obyte_r == 8'd0))
    else $error("output byte not zero for a non-byte status");
  read_before_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == lzd_pkg::E_RDW) |-> ($past(st_r) == lzd_pkg::E_RD))
    else $error("window data used without a read cycle");

endmodule
`default_nettype wire

### src/lz_bitstream_decompressor_top.sv
// A push, restart or unknown request is answered through the output register once
// accepted. A pull runs parse steps in E_PULL, each taking one stream bit; a literal
// byte or offset low field takes one bit per cycle; a copy reads in E_RD, E_RDW.
// Throughput: one request at a time in the engine, a two-entry request queue ahead.
// Reset: rst_n synchronous, active low; clears queues, header and parse state.
`default_nettype none
module lz_bitstream_decompressor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_byte,
  output logic [31:0]      out_total_size,
  output logic             out_size_known
);

  logic          req_valid;
  logic          req_ready;
  lzd_pkg::req_t req;

  // Request queue.
  lzd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_byte     (in_byte),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req)
  );

  // Decoder engine.
  lzd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_byte       (out_byte),
    .out_total_size (out_total_size),
    .out_size_known (out_size_known)
  );

endmodule
`default_nettype wire
